// ----- sv/wlct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the weighted local color transfer block.
// No dependencies; every other file imports this package.
package wlct_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam int NUM_CH          = 3;
  localparam int EXP_ENTRIES     = 4096;
  localparam int EXP_AW          = 12;

  // round(2^32 * exp(-1/256))
  localparam logic [31:0] EXP_STEP    = 32'd4278222805;
  localparam logic [15:0] FALLOFF_RST = 16'd82;
  localparam logic [15:0] W_MAX       = 16'hFFFF;
  localparam logic [7:0]  PIX_MAX     = 8'd255;

  localparam logic [1:0] CH_L = 2'd0;
  localparam logic [1:0] CH_A = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_e;

  typedef enum logic {
    CFG_ACTIVE  = 1'b0,
    CFG_FALLOFF = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_RUN,
    S_HOLD
  } top_state_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_ISSUE,
    L_DRAIN,
    L_DIV
  } lane_state_e;

  // Write of one exp table entry, broadcast to every lane's copy
  typedef struct packed {
    logic              we;
    logic [EXP_AW-1:0] addr;
    logic [15:0]       data;
  } exp_wr_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
  } lane_stat_t;

endpackage

// ----- sv/wlct_exp_init.sv -----
`timescale 1ns / 1ps
// Builds the Q0.16 weight table after reset, one entry per cycle.
// Depends on wlct_pkg.
module wlct_exp_init import wlct_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  output exp_wr_t wr_o,
  output logic    done_o
);

  logic [EXP_AW-1:0] k_q, k_d;
  logic [31:0]       e_q, e_d;
  logic              first_q, first_d;
  logic              busy_q, busy_d;
  logic [63:0]       prod;
  logic [16:0]       rnd;

  always_comb begin
    prod    = 64'(e_q) * 64'(EXP_STEP);
    rnd     = 17'((33'(e_q) + 33'd32768) >> 16);
    k_d     = k_q;
    e_d     = e_q;
    first_d = first_q;
    busy_d  = busy_q;
    wr_o.we   = busy_q;
    wr_o.addr = k_q;
    // Entry zero is exactly 1.0, which saturates
    if (first_q) begin
      wr_o.data = W_MAX;
    end else if (rnd[16]) begin
      wr_o.data = W_MAX;
    end else begin
      wr_o.data = rnd[15:0];
    end
    if (busy_q) begin
      k_d     = k_q + 1'b1;
      first_d = 1'b0;
      e_d     = first_q ? EXP_STEP : prod[63:32];
      if (k_q == EXP_AW'(EXP_ENTRIES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      e_q     <= '0;
      first_q <= 1'b1;
      busy_q  <= 1'b1;
    end else begin
      k_q     <= k_d;
      e_q     <= e_d;
      first_q <= first_d;
      busy_q  <= busy_d;
    end
  end

  assign done_o = !busy_q;

endmodule

// ----- sv/wlct_lane.sv -----
`timescale 1ns / 1ps
// One channel lane: region table, weight pipeline, accumulators and divider.
// Depends on wlct_pkg.
module wlct_lane import wlct_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int CW = $clog2(MAX_REGIONS + 1),
  parameter int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [7:0]    pix_i,
  input  logic [CW-1:0] count_i,
  input  logic [15:0]   falloff_i,
  input  logic          tbl_we_i,
  input  logic [RW-1:0] tbl_addr_i,
  input  logic [47:0]   tbl_data_i,
  input  exp_wr_t       exp_wr_i,
  output lane_stat_t    stat_o
);

  localparam int NUMW = 53 + CW;
  localparam int DENW = 16 + CW;

  logic [47:0] tbl_mem [MAX_REGIONS];
  logic [15:0] exp_mem [EXP_ENTRIES];

  lane_state_e state_q, state_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic [7:0]    pix_q;
  logic          iss;
  logic          v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic [47:0]             rd_q;
  logic signed [16:0]      d1;
  logic signed [16:0]      d2_q;
  logic [15:0]             mag2_q, gain2_q, ref2_q;
  logic [31:0]             sq3_q;
  logic signed [34:0]      m3_q, m4_q, m5_q, m_d;
  logic [47:0]             prod4;
  logic                    zero4_q, zero5_q;
  logic [EXP_AW-1:0]       addr4_q;
  logic [15:0]             w5_q, w_eff;
  logic signed [50:0]      wm6_q;
  logic signed [NUMW-1:0]  num_q;
  logic [DENW-1:0]         den_q;

  logic [NUMW-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [7:0]      quo_q, quo_d, result_q, result_d;
  logic [3:0]      step_q, step_d;
  logic            done_q, done_d, ge;

  always_ff @(posedge clk_i) begin
    if (tbl_we_i) begin
      tbl_mem[tbl_addr_i] <= tbl_data_i;
    end
    rd_q <= tbl_mem[ridx_q[RW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (exp_wr_i.we) begin
      exp_mem[exp_wr_i.addr] <= exp_wr_i.data;
    end
    w5_q <= exp_mem[addr4_q];
  end

  // Datapath stages; table word is {target, reference, gain}
  always_comb begin
    d1    = $signed({1'b0, pix_q, 8'h00}) - $signed({1'b0, rd_q[47:32]});
    m_d   = 35'($signed({1'b0, gain2_q})) * 35'(d2_q) + $signed({7'h00, ref2_q, 12'h000});
    prod4 = 48'(sq3_q) * 48'(falloff_i);
    w_eff = zero5_q ? 16'h0000 : w5_q;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pix_q <= pix_i;
    end
    d2_q    <= d1;
    mag2_q  <= d1[16] ? 16'(-d1) : d1[15:0];
    ref2_q  <= rd_q[31:16];
    gain2_q <= rd_q[15:0];
    sq3_q   <= 32'(mag2_q) * 32'(mag2_q);
    m3_q    <= m_d;
    zero4_q <= |prod4[47:36];
    addr4_q <= prod4[35:24];
    m4_q    <= m3_q;
    zero5_q <= zero4_q;
    m5_q    <= m4_q;
    wm6_q   <= $signed({35'd0, w_eff}) * 51'(m5_q);
    if (start_i) begin
      den_q <= '0;
      num_q <= '0;
    end else begin
      if (v5_q) begin
        den_q <= den_q + DENW'(w_eff);
      end
      if (v6_q) begin
        num_q <= num_q + NUMW'(wm6_q);
      end
    end
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  always_comb begin
    state_d  = state_q;
    ridx_d   = ridx_q;
    step_d   = step_q;
    done_d   = done_q;
    result_d = result_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    iss      = 1'b0;
    ge       = rem_q >= dsh_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          done_d  = 1'b0;
          ridx_d  = '0;
          state_d = (count_i == '0) ? L_DRAIN : L_ISSUE;
        end
      end
      L_ISSUE: begin
        iss    = 1'b1;
        ridx_d = ridx_q + 1'b1;
        if (ridx_q == count_i - 1'b1) begin
          state_d = L_DRAIN;
        end
      end
      L_DRAIN: begin
        if (!(v1_q || v2_q || v3_q || v4_q || v5_q || v6_q)) begin
          if (den_q == '0 || num_q[NUMW-1]) begin
            result_d = '0;
            done_d   = 1'b1;
            state_d  = L_IDLE;
          end else begin
            rem_d   = num_q;
            dsh_d   = NUMW'(den_q) << 28;
            quo_d   = '0;
            step_d  = 4'd8;
            state_d = L_DIV;
          end
        end
      end
      L_DIV: begin
        dsh_d = dsh_q >> 1;
        if (step_q == 4'd8) begin
          // quotient of 256 or more clamps
          step_d = 4'd7;
          if (ge) begin
            result_d = PIX_MAX;
            done_d   = 1'b1;
            state_d  = L_IDLE;
          end
        end else begin
          if (ge) begin
            rem_d = rem_q - dsh_q;
          end
          quo_d  = {quo_q[6:0], ge};
          step_d = step_q - 1'b1;
          if (step_q == 4'd0) begin
            result_d = {quo_q[6:0], ge};
            done_d   = 1'b1;
            state_d  = L_IDLE;
          end
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      ridx_q   <= '0;
      step_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      v6_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ridx_q   <= ridx_d;
      step_q   <= step_d;
      done_q   <= done_d;
      result_q <= result_d;
      v1_q     <= iss;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
    end
  end

  assign stat_o.done   = done_q;
  assign stat_o.result = result_q;

endmodule

// ----- sv/weighted_local_color_transfer_top.sv -----
`timescale 1ns / 1ps
// Top level: handshakes, configuration, load decode, three channel lanes and merge.
// Depends on wlct_pkg, wlct_exp_init and wlct_lane.
//
// After reset the block builds its exp weight table and takes no word until that
// is done; configuration writes are taken at any time.
// A load word is taken in the idle state and leaves the block ready. A pixel word
// runs its L, A and B channels in three lanes side by side; each lane reads one
// region table entry per cycle, and a pixel holds the input through N table
// reads, with N the number of active regions, the drain of the weight pipeline,
// a check of the sums, the eight-bit restoring divide and the merge of the result.
// Results sit in an output register, so a new word is taken while one waits.
module weighted_local_color_transfer_top import wlct_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [3:0]  region_index_i,
  input  logic [1:0]  channel_select_i,
  input  logic [15:0] target_mean_i,
  input  logic [15:0] reference_mean_i,
  input  logic [15:0] gain_i,
  input  logic [7:0]  pixel_l_i,
  input  logic [7:0]  pixel_a_i,
  input  logic [7:0]  pixel_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_l_o,
  output logic [7:0]  out_a_o,
  output logic [7:0]  out_b_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  top_state_e  state_q, state_d;
  logic [4:0]  active_q;
  logic [15:0] falloff_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_l_q, out_a_q, out_b_q;
  logic        acc, start, load_ok, all_done, take;
  logic [CW-1:0] count;
  logic [NUM_CH-1:0] tbl_we;
  exp_wr_t     exp_wr;
  logic        init_done;
  lane_stat_t  stat [NUM_CH];
  logic [7:0]  pix [NUM_CH];

  assign acc     = in_valid_i && in_ready_o;
  assign start   = acc && (opcode_i == OP_PIXEL);
  assign load_ok = acc && (opcode_i == OP_LOAD) && (32'(region_index_i) < MAX_REGIONS);
  assign tbl_we[0] = load_ok && (channel_select_i == CH_L);
  assign tbl_we[1] = load_ok && (channel_select_i == CH_A);
  assign tbl_we[2] = load_ok && (channel_select_i == CH_B);
  assign count = (32'(active_q) > MAX_REGIONS) ? CW'(MAX_REGIONS) : CW'(active_q);
  assign pix[0] = pixel_l_i;
  assign pix[1] = pixel_a_i;
  assign pix[2] = pixel_b_i;

  wlct_exp_init u_exp_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (exp_wr),
    .done_o (init_done)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    wlct_lane #(
      .MAX_REGIONS (MAX_REGIONS),
      .CW          (CW),
      .RW          (RW)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (start),
      .pix_i      (pix[c]),
      .count_i    (count),
      .falloff_i  (falloff_q),
      .tbl_we_i   (tbl_we[c]),
      .tbl_addr_i (RW'(region_index_i)),
      .tbl_data_i ({target_mean_i, reference_mean_i, gain_i}),
      .exp_wr_i   (exp_wr),
      .stat_o     (stat[c])
    );
  end

  assign all_done = stat[0].done && stat[1].done && stat[2].done;

  // Merge: move lane results into the output register once it is free
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    take        = 1'b0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_INIT: begin
        if (init_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (start) begin
          state_d = S_RUN;
        end
      end
      S_RUN, S_HOLD: begin
        if (all_done && (!out_valid_q || out_ready_i)) begin
          take        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (all_done) begin
          state_d = S_HOLD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      active_q    <= '0;
      falloff_q   <= FALLOFF_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_ACTIVE:  active_q  <= cfg_data_i[4:0];
          CFG_FALLOFF: falloff_q <= cfg_data_i;
          default:     active_q  <= active_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_l_q <= stat[0].result;
      out_a_q <= stat[1].result;
      out_b_q <= stat[2].result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_l_o     = out_l_q;
  assign out_a_o     = out_a_q;
  assign out_b_o     = out_b_q;

  // Hold a waiting result word until the receiver takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable({out_l_q, out_a_q, out_b_q})))
    else $error("result word dropped or changed while waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> init_done)
    else $error("word taken before weight table is built");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(all_done))
    else $error("result word raised without finished lanes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !stat[0].done)
    else $error("lane done not cleared by a pixel word");

endmodule
